// ----- src/wash_sequence_controller_defines.svh -----
// Assertion macros used by the wash sequence controller top level.
`ifndef WASH_SEQUENCE_CONTROLLER_DEFINES_SVH
`define WASH_SEQUENCE_CONTROLLER_DEFINES_SVH

// Same-cycle implication, clocked on clk and disabled while arst_n is low.
`define WSC_ASSERT_IMPL(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk and disabled while arst_n is low.
`define WSC_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/wsc_pkg.sv -----
// Types, codes and constants of the wash sequence controller.
package wsc_pkg;

	typedef enum logic [2:0] {
		PH_IDLE = 3'd0,
		PH_FWD  = 3'd1,
		PH_PUMP = 3'd2,
		PH_BACK = 3'd3,
		PH_WEAK = 3'd4,
		PH_DRY  = 3'd5
	} phase_t;

	localparam logic [1:0] CMD_TICK = 2'd0;
	localparam logic [1:0] CMD_KEY  = 2'd1;
	localparam logic [1:0] CMD_SEAT = 2'd2;

	localparam logic [3:0] KEY_STOP     = 4'd0;
	localparam logic [3:0] KEY_WASH     = 4'd1;
	localparam logic [3:0] KEY_RINSE    = 4'd2;
	localparam logic [3:0] KEY_DRY      = 4'd3;
	localparam logic [3:0] KEY_POS_DOWN = 4'd4;
	localparam logic [3:0] KEY_POS_UP   = 4'd5;
	localparam logic [3:0] KEY_HEAT     = 4'd7;
	localparam logic [3:0] KEY_PRES_DN  = 4'd8;
	localparam logic [3:0] KEY_PRES_UP  = 4'd9;
	localparam logic [3:0] KEY_BEEP     = 4'd12;

	localparam logic [1:0] MOT_STILL = 2'd0;
	localparam logic [1:0] MOT_FWD   = 2'd1;
	localparam logic [1:0] MOT_BACK  = 2'd2;

	localparam int unsigned CFG_COUNT = 7;
	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_RINSE_BASE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WASH_BASE  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_STEP       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PUMP       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_WEAK       = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_DRY        = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_BEEP       = 3'd6;

	localparam logic [15:0] HEAT_LIT_MS = 16'd1000;

	typedef struct packed {
		logic [15:0] rinse_travel_base;
		logic [15:0] wash_travel_base;
		logic [15:0] travel_step;
		logic [15:0] pump_time;
		logic [15:0] weak_time;
		logic [15:0] dry_time;
		logic [15:0] beep_time;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		rinse_travel_base: 16'd1000,
		wash_travel_base:  16'd2000,
		travel_step:       16'd500,
		pump_time:         16'd5000,
		weak_time:         16'd1000,
		dry_time:          16'd3000,
		beep_time:         16'd100
	};

	typedef struct packed {
		logic [2:0] phase_code;
		logic [7:0] pump_duty;
		logic [1:0] nozzle_motion;
		logic       fan_on;
		logic       heater_on;
		logic       beep_on;
		logic [1:0] pressure_level;
		logic [1:0] heat_level;
		logic [1:0] phase_position;
		logic       manual_drying;
		logic       running;
	} res_t;

	function automatic logic [7:0] duty_lut(input logic [1:0] lvl);
		logic [7:0] d;
		unique case (lvl)
			2'd0: d = 8'd0;
			2'd1: d = 8'd64;
			2'd2: d = 8'd128;
			2'd3: d = 8'd255;
			default: d = 8'd0;
		endcase
		return d;
	endfunction

	function automatic logic [15:0] heat_dark_ms(input logic [1:0] setting);
		logic [15:0] t;
		unique case (setting)
			2'd1: t = 16'd1000;
			2'd2: t = 16'd2000;
			2'd3: t = 16'd3000;
			default: t = 16'd0;
		endcase
		return t;
	endfunction

endpackage

// ----- src/wsc_in_if.sv -----
// Event channel: one command, key code and seat level per transfer.
interface wsc_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] command;
	logic [3:0] key_code;
	logic       seat_level;

	modport source(output valid, command, key_code, seat_level, input ready);
	modport sink(input valid, command, key_code, seat_level, output ready);
endinterface

// ----- src/wsc_out_if.sv -----
// Result channel: the controller outputs after one event per transfer.
interface wsc_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] phase_code;
	logic [7:0] pump_duty;
	logic [1:0] nozzle_motion;
	logic       fan_on;
	logic       heater_on;
	logic       beep_on;
	logic [1:0] pressure_level;
	logic [1:0] heat_level;
	logic [1:0] phase_position;
	logic       manual_drying;
	logic       running;

	modport source(output valid, phase_code, pump_duty, nozzle_motion, fan_on, heater_on,
		beep_on, pressure_level, heat_level, phase_position, manual_drying, running,
		input ready);
	modport sink(input valid, phase_code, pump_duty, nozzle_motion, fan_on, heater_on,
		beep_on, pressure_level, heat_level, phase_position, manual_drying, running,
		output ready);
endinterface

// ----- src/wsc_core.sv -----
// Sequencer state register and the next-state logic for one event.
module wsc_core import wsc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [1:0] command,
	input  logic [3:0] key_code,
	input  logic       seat_level,
	input  cfg_t       cfg,
	output res_t       res
);

	typedef struct packed {
		phase_t      phase;
		logic [15:0] phase_elapsed;
		logic        stop_pending;
		logic        running;
		logic        wash_sel;
		logic [1:0]  nozzle_step;
		logic [1:0]  water_level;
		logic [1:0]  heat_setting;
		logic        dry_manual;
		logic [15:0] dry_elapsed;
		logic        seat_present;
		logic        fan;
		logic        heater_lit;
		logic [15:0] heater_elapsed;
		logic        beep_active;
		logic [15:0] beep_elapsed;
		logic [7:0]  duty;
	} st_t;

	localparam st_t ST_RESET = '{
		phase: PH_IDLE, phase_elapsed: 16'd0, stop_pending: 1'b0, running: 1'b0,
		wash_sel: 1'b0, nozzle_step: 2'd1, water_level: 2'd1, heat_setting: 2'd0,
		dry_manual: 1'b0, dry_elapsed: 16'd0, seat_present: 1'b0, fan: 1'b0,
		heater_lit: 1'b0, heater_elapsed: 16'd0, beep_active: 1'b0,
		beep_elapsed: 16'd0, duty: 8'd0
	};

	st_t st_q;
	st_t st_d;

	function automatic logic [15:0] sat_inc(input logic [15:0] v);
		return (v == 16'hFFFF) ? v : v + 16'd1;
	endfunction

	function automatic st_t beep_start(input st_t s);
		st_t r;
		r = s;
		r.beep_active = 1'b1;
		r.beep_elapsed = '0;
		return r;
	endfunction

	function automatic st_t go_phase(input st_t s, input phase_t p);
		st_t r;
		r = s;
		r.phase = p;
		r.phase_elapsed = '0;
		unique case (p)
			PH_IDLE: begin
				r.duty = '0;
				r.fan = 1'b0;
			end
			PH_PUMP: r.duty = duty_lut(s.water_level);
			PH_WEAK: r.duty = duty_lut(2'd1);
			PH_DRY: begin
				r.duty = '0;
				r.fan = 1'b1;
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic logic [15:0] travel_ms(input st_t s, input cfg_t c);
		logic [17:0] t;
		logic [17:0] extra;
		t = {2'b00, (s.wash_sel ? c.wash_travel_base : c.rinse_travel_base)};
		unique case (s.nozzle_step)
			2'd2: extra = {2'b00, c.travel_step};
			2'd3: extra = {1'b0, c.travel_step, 1'b0};
			default: extra = '0;
		endcase
		t = t + extra;
		return (t > 18'h0FFFF) ? 16'hFFFF : t[15:0];
	endfunction

	function automatic st_t halt_all(input st_t s);
		st_t r;
		r = beep_start(s);
		r.stop_pending = 1'b1;
		if (r.dry_manual) begin
			r.fan = 1'b0;
			r.dry_manual = 1'b0;
		end
		if (r.running) begin
			r.running = 1'b0;
			if (r.phase == PH_FWD || r.phase == PH_PUMP) begin
				r = go_phase(r, PH_BACK);
			end else begin
				r = go_phase(r, PH_IDLE);
			end
		end
		return r;
	endfunction

	function automatic st_t end_to_idle(input st_t s);
		st_t r;
		r = go_phase(s, PH_IDLE);
		r.stop_pending = 1'b0;
		return r;
	endfunction

	function automatic st_t do_tick(input st_t s, input cfg_t c);
		st_t r;
		logic [15:0] e;
		r = s;
		r.phase_elapsed = sat_inc(s.phase_elapsed);
		r.dry_elapsed = sat_inc(s.dry_elapsed);
		r.heater_elapsed = sat_inc(s.heater_elapsed);
		r.beep_elapsed = sat_inc(s.beep_elapsed);
		e = r.phase_elapsed;
		unique case (s.phase)
			PH_FWD: begin
				if (e >= travel_ms(r, c)) r = go_phase(r, PH_PUMP);
			end
			PH_PUMP: begin
				if (e >= c.pump_time) r = go_phase(r, PH_BACK);
			end
			PH_BACK: begin
				if (e >= travel_ms(r, c)) begin
					if (r.stop_pending) r = end_to_idle(r);
					else r = go_phase(r, PH_WEAK);
				end
			end
			PH_WEAK: begin
				if (r.stop_pending) r = end_to_idle(r);
				else if (e >= c.weak_time) r = go_phase(r, PH_DRY);
			end
			PH_DRY: begin
				if (r.stop_pending || e >= c.dry_time) r = end_to_idle(r);
			end
			default: ;
		endcase
		if (r.dry_manual && r.dry_elapsed >= c.dry_time) begin
			r.fan = 1'b0;
			r.dry_manual = 1'b0;
		end
		if (r.beep_active && r.beep_elapsed >= c.beep_time) r.beep_active = 1'b0;
		if (r.heat_setting == 2'd0) begin
			r.heater_lit = 1'b0;
		end else if (!r.heater_lit && r.heater_elapsed >= heat_dark_ms(r.heat_setting)) begin
			r.heater_lit = 1'b1;
			r.heater_elapsed = '0;
		end else if (r.heater_lit && r.heater_elapsed >= HEAT_LIT_MS) begin
			r.heater_lit = 1'b0;
			r.heater_elapsed = '0;
		end
		return r;
	endfunction

	function automatic st_t do_key(input st_t s, input logic [3:0] k);
		st_t r;
		logic in_pump;
		logic adjust;
		r = s;
		in_pump = (s.phase == PH_PUMP) || (s.phase == PH_WEAK);
		adjust = s.seat_present && s.running && in_pump;
		unique case (k)
			KEY_STOP: begin
				if (s.seat_present) r = halt_all(s);
			end
			KEY_WASH, KEY_RINSE: begin
				if (s.seat_present && s.phase == PH_IDLE) begin
					r = beep_start(s);
					r.running = 1'b1;
					r.wash_sel = (k == KEY_WASH);
					r = go_phase(r, PH_FWD);
				end
			end
			KEY_DRY: begin
				if (!s.dry_manual && s.seat_present) begin
					r = beep_start(s);
					r.fan = 1'b1;
					r.dry_manual = 1'b1;
					r.dry_elapsed = '0;
				end
			end
			KEY_POS_DOWN: begin
				if (adjust) begin
					r = beep_start(s);
					if (s.nozzle_step > 2'd1) r.nozzle_step = s.nozzle_step - 2'd1;
				end
			end
			KEY_POS_UP: begin
				if (adjust) begin
					r = beep_start(s);
					if (s.nozzle_step < 2'd3) r.nozzle_step = s.nozzle_step + 2'd1;
				end
			end
			KEY_HEAT: begin
				if (!s.dry_manual) begin
					r = beep_start(s);
					r.heat_setting = s.heat_setting + 2'd1;
				end
			end
			KEY_PRES_DN: begin
				if (!s.dry_manual && s.seat_present) begin
					r = beep_start(s);
					if (s.water_level > 2'd1) r.water_level = s.water_level - 2'd1;
				end
			end
			KEY_PRES_UP: begin
				if (!s.dry_manual && s.seat_present) begin
					r = beep_start(s);
					if (s.water_level < 2'd3) r.water_level = s.water_level + 2'd1;
				end
			end
			KEY_BEEP: r = beep_start(s);
			default: ;
		endcase
		return r;
	endfunction

	function automatic st_t do_seat(input st_t s, input logic lvl);
		st_t r;
		r = s;
		if (lvl && !s.seat_present) begin
			r = beep_start(s);
			r.seat_present = 1'b1;
		end else if (!lvl && s.seat_present) begin
			r = halt_all(s);
			r.seat_present = 1'b0;
		end
		return r;
	endfunction

	always_comb begin
		st_d = st_q;
		if (step) begin
			unique case (command)
				CMD_TICK: st_d = do_tick(st_q, cfg);
				CMD_KEY:  st_d = do_key(st_q, key_code);
				CMD_SEAT: st_d = do_seat(st_q, seat_level);
				default:  st_d = st_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_RESET;
		end else begin
			st_q <= st_d;
		end
	end

	always_comb begin
		res.phase_code = st_d.phase;
		res.pump_duty = st_d.duty;
		unique case (st_d.phase)
			PH_FWD:  res.nozzle_motion = MOT_FWD;
			PH_BACK: res.nozzle_motion = MOT_BACK;
			default: res.nozzle_motion = MOT_STILL;
		endcase
		res.fan_on = st_d.fan;
		res.heater_on = st_d.heater_lit;
		res.beep_on = st_d.beep_active;
		res.pressure_level = st_d.water_level;
		res.heat_level = st_d.heat_setting;
		res.phase_position = st_d.nozzle_step;
		res.manual_drying = st_d.dry_manual;
		res.running = st_d.running;
	end

endmodule

// ----- src/wash_sequence_controller.sv -----
// Top level of the wash sequence controller: handshake, registers and result stage.
//
// Events enter on the item channel (command 0 tick, 1 key press, 2 seat sample)
// and each one yields exactly one transfer on the result channel, carrying all
// controller outputs as they stand after that event.
// A transfer takes place at a rising edge with valid and ready both high.
// An accepted event waits in an input register until the output register is empty or
// its result is being taken; it is then applied to the sequencer state, and its result
// is loaded into the output register at the same edge as the state update.
// One event per cycle is taken in sustained operation while the receiver takes each
// result; the state update of an event is made while it sits in the input register.
// When the receiver stalls, the result holds and one more event can wait in
// the input register; ready then drops until the result is taken.
// Timing registers are written through wr_en, wr_index and wr_data; the user must
// write them only while the block is idle, which the block itself does not enforce;
// an index past the last register is ignored. Reset clears both stages, restores the
// register defaults and puts the sequencer in idle with pressure and nozzle position one and heat off.
`include "wash_sequence_controller_defines.svh"

module wash_sequence_controller import wsc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	wsc_in_if.sink               item,
	wsc_out_if.source            result,
	input  logic                 wr_en,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  logic [15:0]          wr_data
);

	cfg_t       cfg_q;
	logic       v_s1;
	logic [1:0] cmd_s1;
	logic [3:0] key_s1;
	logic       seat_s1;
	logic       adv;
	logic       out_v_q;
	res_t       res_d;
	res_t       out_q;

	assign adv = v_s1 && (!out_v_q || result.ready);
	assign item.ready = !v_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				CFG_RINSE_BASE: cfg_q.rinse_travel_base <= wr_data;
				CFG_WASH_BASE:  cfg_q.wash_travel_base <= wr_data;
				CFG_STEP:       cfg_q.travel_step <= wr_data;
				CFG_PUMP:       cfg_q.pump_time <= wr_data;
				CFG_WEAK:       cfg_q.weak_time <= wr_data;
				CFG_DRY:        cfg_q.dry_time <= wr_data;
				CFG_BEEP:       cfg_q.beep_time <= wr_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (item.valid && item.ready) v_s1 <= 1'b1;
			else if (adv) v_s1 <= 1'b0;
			if (adv) out_v_q <= 1'b1;
			else if (result.ready) out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			cmd_s1 <= item.command;
			key_s1 <= item.key_code;
			seat_s1 <= item.seat_level;
		end
		if (adv) out_q <= res_d;
	end

	wsc_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (adv),
		.command    (cmd_s1),
		.key_code   (key_s1),
		.seat_level (seat_s1),
		.cfg        (cfg_q),
		.res        (res_d)
	);

	assign result.valid = out_v_q;
	assign result.phase_code = out_q.phase_code;
	assign result.pump_duty = out_q.pump_duty;
	assign result.nozzle_motion = out_q.nozzle_motion;
	assign result.fan_on = out_q.fan_on;
	assign result.heater_on = out_q.heater_on;
	assign result.beep_on = out_q.beep_on;
	assign result.pressure_level = out_q.pressure_level;
	assign result.heat_level = out_q.heat_level;
	assign result.phase_position = out_q.phase_position;
	assign result.manual_drying = out_q.manual_drying;
	assign result.running = out_q.running;

	`WSC_ASSERT_NEXT(a_s1_holds, v_s1 && !adv, v_s1 && $stable(cmd_s1), "stalled event lost")
	`WSC_ASSERT_NEXT(a_result_loads, adv, out_v_q, "applied event produced no result")
	`WSC_ASSERT_IMPL(a_phase_range, out_v_q, out_q.phase_code <= PH_DRY, "phase out of range")
	`WSC_ASSERT_IMPL(a_motion_phase, out_v_q && (out_q.nozzle_motion != MOT_STILL),
		(out_q.phase_code == PH_FWD) || (out_q.phase_code == PH_BACK), "motion outside travel")
	`WSC_ASSERT_IMPL(a_levels_nonzero, out_v_q,
		(out_q.pressure_level != 2'd0) && (out_q.phase_position != 2'd0), "level at zero")

endmodule
